// ----- rtl/mss_pkg.sv -----
// Shared types, constants and helper functions of the minimum-sum sub-rectangle search.
package mss_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int MAX_DIM  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W  = $clog2(MAX_DIM + 1);
    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int ENERGY_W  = 16;
    localparam int SUM_W     = ENERGY_W + ADDR_W;
    localparam int MIN_SUM_W = 28;
    localparam int START_W   = 6;
    localparam int COUNT_W   = 7;
    localparam int EXT_W     = (SUM_W > MIN_SUM_W) ? SUM_W : MIN_SUM_W;

    localparam int CFG_W       = 7;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS_USED = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_COLS_USED = CFG_INDEX_W'(1);
    localparam logic [CFG_W-1:0]       CFG_SIZE_RST  = CFG_W'(64);

    typedef logic signed [ENERGY_W-1:0]  energy_t;
    typedef logic signed [SUM_W-1:0]     sum_t;
    typedef logic signed [MIN_SUM_W-1:0] min_sum_t;
    typedef logic [ADDR_W-1:0]           addr_t;
    typedef logic [ROW_W-1:0]            row_t;
    typedef logic [COL_W-1:0]            col_t;
    typedef logic [CNT_W-1:0]            cnt_t;
    typedef logic [START_W-1:0]          start_t;
    typedef logic [COUNT_W-1:0]          count_t;

    localparam sum_t SUM_HI = {1'b0, {(SUM_W-1){1'b1}}};

    localparam logic signed [EXT_W-1:0] OUT_HI =
        EXT_W'((longint'(1) << (MIN_SUM_W - 1)) - longint'(1));
    localparam logic signed [EXT_W-1:0] OUT_LO =
        EXT_W'(-(longint'(1) << (MIN_SUM_W - 1)));

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CORNER,
        ST_RECT,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ROWSUM,
        OP_LOAD,
        OP_CORNER,
        OP_RECT
    } op_t;

    // Per-cycle control from the sequencer to the datapath
    typedef struct packed {
        logic  ready;
        op_t   op;
        logic  m_top;
        logic  m_left;
        logic  wr_en;
        addr_t waddr;
        addr_t raddr0;
        addr_t raddr1;
        row_t  x1;
        col_t  y1;
        row_t  x2;
        col_t  y2;
        logic  scan_start;
        logic  res_load;
    } ctrl_t;

    function automatic addr_t mem_addr(input row_t row, input col_t col);
        return ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
    endfunction

    function automatic cnt_t clamp_size(input logic [CFG_W-1:0] v, input int maxv);
        if (v == '0) begin
            return CNT_W'(1);
        end
        if (int'(v) > maxv) begin
            return CNT_W'(maxv);
        end
        return CNT_W'(v);
    endfunction

    function automatic min_sum_t sat_sum(input sum_t s);
        logic signed [EXT_W-1:0] w;
        w = EXT_W'(s);
        if (w > OUT_HI) begin
            w = OUT_HI;
        end
        else if (w < OUT_LO) begin
            w = OUT_LO;
        end
        return MIN_SUM_W'(w);
    endfunction

endpackage

// ----- rtl/mss_ifs.sv -----
// Valid/ready channel interfaces for matrix cells and search results.
interface mss_cell_if;
    logic              valid;
    logic              ready;
    mss_pkg::energy_t  energy;

    modport source (output valid, output energy, input ready);
    modport sink   (input valid, input energy, output ready);
endinterface

interface mss_result_if;
    logic               valid;
    logic               ready;
    mss_pkg::min_sum_t  min_sum;
    mss_pkg::start_t    row_start;
    mss_pkg::count_t    row_count;
    mss_pkg::start_t    col_start;
    mss_pkg::count_t    col_count;

    modport source (output valid, output min_sum, output row_start, output row_count,
                    output col_start, output col_count, input ready);
    modport sink   (input valid, input min_sum, input row_start, input row_count,
                    input col_start, input col_count, output ready);
endinterface

// ----- rtl/min_sum_subrectangle_search_core.sv -----
// Top level of the minimum-sum sub-rectangle search: config, datapath and result register.
//
//  Channel   Kind          Moves                          Accepted when
//  cells     valid/ready   one energy cell, row-major     valid && ready
//  result    valid/ready   min sum, start and counts      valid && ready
//  cfg       write only    rows_used / cols_used          cfg_we
//
// A cell that is not the last of a job is accepted, then written into the table before the next is taken.
// The last cell starts the search, which evaluates one rectangle per cycle through the
// two read ports of the summed-area table, plus one corner fetch per (top, left, bottom).
// Reset leaves the block loading at row 0, column 0 with both sizes at 64; the table
// itself is not cleared, only entries of the current job are ever read.
// A stalled result holds in the output register; cells are taken again once it is loaded.
module min_sum_subrectangle_search_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mss_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mss_pkg::CFG_W-1:0]           cfg_wdata,
    mss_cell_if.sink                            cells,
    mss_result_if.source                        result
);

    // Size registers, clamped into 1..MAX before use
    logic [mss_pkg::CFG_W-1:0] rows_used_reg;
    logic [mss_pkg::CFG_W-1:0] cols_used_reg;
    mss_pkg::cnt_t             nr, nc;
    logic                      restart;

    mss_pkg::ctrl_t ctrl;
    logic           accept;
    logic           out_free;

    // Datapath registers
    mss_pkg::sum_t rowsum_reg;
    mss_pkg::sum_t corner_reg;
    mss_pkg::sum_t best_sum_reg;
    mss_pkg::row_t best_x1_reg, best_x2_reg;
    mss_pkg::col_t best_y1_reg, best_y2_reg;

    // Result register
    logic              out_valid_reg;
    mss_pkg::min_sum_t min_sum_reg;
    mss_pkg::start_t   row_start_reg, col_start_reg;
    mss_pkg::count_t   row_count_reg, col_count_reg;

    // Table and shared unit
    mss_pkg::sum_t rdata0, rdata1;
    mss_pkg::sum_t op_a, op_b, op_c;
    mss_pkg::sum_t alu_sum;
    logic          alu_less;

    assign nr      = mss_pkg::clamp_size(rows_used_reg, mss_pkg::MAX_ROWS);
    assign nc      = mss_pkg::clamp_size(cols_used_reg, mss_pkg::MAX_COLS);
    assign restart = cfg_we && ((cfg_index == mss_pkg::CFG_ROWS_USED) ||
                                (cfg_index == mss_pkg::CFG_COLS_USED));

    assign accept   = cells.valid && ctrl.ready;
    assign out_free = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_used_reg <= mss_pkg::CFG_SIZE_RST;
            cols_used_reg <= mss_pkg::CFG_SIZE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mss_pkg::CFG_ROWS_USED: rows_used_reg <= cfg_wdata;
                mss_pkg::CFG_COLS_USED: cols_used_reg <= cfg_wdata;
                default:                rows_used_reg <= rows_used_reg;
            endcase
        end
    end

    mss_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .nr       (nr),
        .nc       (nc),
        .restart  (restart),
        .accept   (accept),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    mss_ram #(
        .DATA_W (mss_pkg::SUM_W),
        .ADDR_W (mss_pkg::ADDR_W),
        .DEPTH  (mss_pkg::DEPTH)
    ) u_ram (
        .clk    (clk),
        .we     (ctrl.wr_en),
        .waddr  (ctrl.waddr),
        .wdata  (alu_sum),
        .raddr0 (ctrl.raddr0),
        .raddr1 (ctrl.raddr1),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    // Operand selection for the shared unit, computing a - b + c:
    //   row sum   : running row sum (zero at column 0) plus the new cell
    //   table word: row sum plus the entry above (zero on row 0)
    //   corner    : top-left diagonal entry minus left entry, each masked at the edges
    //   rectangle : bottom-right minus top-right plus the held corner term
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        op_c = '0;
        unique case (ctrl.op)
            mss_pkg::OP_ROWSUM:
            begin
                op_a = ctrl.m_left ? rowsum_reg : '0;
                op_c = mss_pkg::SUM_W'(cells.energy);
            end
            mss_pkg::OP_LOAD:
            begin
                op_a = ctrl.m_top ? rdata0 : '0;
                op_c = rowsum_reg;
            end
            mss_pkg::OP_CORNER:
            begin
                op_a = (ctrl.m_top && ctrl.m_left) ? rdata1 : '0;
                op_b = ctrl.m_left ? rdata0 : '0;
            end
            mss_pkg::OP_RECT:
            begin
                op_a = rdata0;
                op_b = ctrl.m_top ? rdata1 : '0;
                op_c = corner_reg;
            end
            default:
            begin
                op_a = '0;
            end
        endcase
    end

    mss_alu u_alu (
        .a    (op_a),
        .b    (op_b),
        .c    (op_c),
        .best (best_sum_reg),
        .sum  (alu_sum),
        .less (alu_less)
    );

    // Hold the row sum across a row; take the corner term and track the best
    always_ff @(posedge clk)
    begin
        if (ctrl.op == mss_pkg::OP_ROWSUM && accept)
        begin
            rowsum_reg <= alu_sum;
        end
        if (ctrl.op == mss_pkg::OP_CORNER)
        begin
            corner_reg <= alu_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_sum_reg <= mss_pkg::SUM_HI;
            best_x1_reg  <= '0;
            best_y1_reg  <= '0;
            best_x2_reg  <= '0;
            best_y2_reg  <= '0;
        end
        else if (ctrl.scan_start)
        begin
            best_sum_reg <= mss_pkg::SUM_HI;
        end
        else if (ctrl.op == mss_pkg::OP_RECT && alu_less)
        begin
            // Strictly smaller only: the first rectangle in scan order keeps a tie
            best_sum_reg <= alu_sum;
            best_x1_reg  <= ctrl.x1;
            best_y1_reg  <= ctrl.y1;
            best_x2_reg  <= ctrl.x2;
            best_y2_reg  <= ctrl.y2;
        end
    end

    // Result register: load at the end of a search, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.res_load)
        begin
            min_sum_reg   <= mss_pkg::sat_sum(best_sum_reg);
            row_start_reg <= mss_pkg::START_W'(best_x1_reg);
            col_start_reg <= mss_pkg::START_W'(best_y1_reg);
            row_count_reg <= mss_pkg::COUNT_W'(best_x2_reg) - mss_pkg::COUNT_W'(best_x1_reg)
                             + mss_pkg::COUNT_W'(1);
            col_count_reg <= mss_pkg::COUNT_W'(best_y2_reg) - mss_pkg::COUNT_W'(best_y1_reg)
                             + mss_pkg::COUNT_W'(1);
        end
    end

    assign cells.ready      = ctrl.ready;
    assign result.valid     = out_valid_reg;
    assign result.min_sum   = min_sum_reg;
    assign result.row_start = row_start_reg;
    assign result.row_count = row_count_reg;
    assign result.col_start = col_start_reg;
    assign result.col_count = col_count_reg;

`ifndef SYNTHESIS
    a_write_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.wr_en |-> $past(cells.valid && cells.ready))
        else $error("table write without a preceding cell");

    a_no_cell_during_search: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == mss_pkg::OP_RECT || ctrl.op == mss_pkg::OP_CORNER) |-> !cells.ready)
        else $error("cell input open during the search");

    a_best_never_rises: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == mss_pkg::OP_RECT && !ctrl.scan_start) |=>
            (best_sum_reg <= $past(best_sum_reg)))
        else $error("best sum increased during the search");

    a_result_counts_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.row_count != '0) && (result.col_count != '0))
        else $error("result with an empty rectangle");
`endif

endmodule

// ----- rtl/mss_ram.sv -----
// Generic one-write, two-read RAM with registered read data.
module mss_ram #(
    parameter int DATA_W = 28,
    parameter int ADDR_W = 12,
    parameter int DEPTH  = 4096
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr0,
    input  logic [ADDR_W-1:0] raddr1,
    output logic [DATA_W-1:0] rdata0,
    output logic [DATA_W-1:0] rdata1
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata0_reg;
    logic [DATA_W-1:0] rdata1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0_reg <= mem[raddr0];
        rdata1_reg <= mem[raddr1];
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

// ----- rtl/mss_alu.sv -----
// Shared three-operand adder with minimum compare.
module mss_alu (
    input  mss_pkg::sum_t a,
    input  mss_pkg::sum_t b,
    input  mss_pkg::sum_t c,
    input  mss_pkg::sum_t best,
    output mss_pkg::sum_t sum,
    output logic          less
);

    // a - b + c, wrapping: every true result fits the width
    assign sum  = a - b + c;
    assign less = (sum < best);

endmodule

// ----- rtl/mss_seq.sv -----
// Sequencer: load position, rectangle scan counters and table addressing.
module mss_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  mss_pkg::cnt_t   nr,
    input  mss_pkg::cnt_t   nc,
    input  logic            restart,
    input  logic            accept,
    input  logic            out_free,
    output mss_pkg::ctrl_t  ctrl
);

    mss_pkg::state_t state_reg, state_next;
    mss_pkg::row_t   load_row_reg, load_row_next;
    mss_pkg::col_t   load_col_reg, load_col_next;
    mss_pkg::row_t   x1_reg, x1_next, x2_reg, x2_next;
    mss_pkg::col_t   y1_reg, y1_next, y2_reg, y2_next;
    mss_pkg::op_t    pend_op_reg, pend_op_next;
    logic            pend_top_reg, pend_top_next;
    logic            pend_left_reg, pend_left_next;
    mss_pkg::row_t   px1_reg, px2_reg;
    mss_pkg::col_t   py1_reg, py2_reg;

    logic          col_last, row_last;
    logic          y2_last, y1_last, x2_last, x1_last;
    mss_pkg::row_t load_prev_row, x1_prev;
    mss_pkg::col_t y1_prev;

    assign col_last = (mss_pkg::CNT_W'(load_col_reg) + mss_pkg::CNT_W'(1)) == nc;
    assign row_last = (mss_pkg::CNT_W'(load_row_reg) + mss_pkg::CNT_W'(1)) == nr;
    assign y2_last  = (mss_pkg::CNT_W'(y2_reg) + mss_pkg::CNT_W'(1)) == nc;
    assign y1_last  = (mss_pkg::CNT_W'(y1_reg) + mss_pkg::CNT_W'(1)) == nc;
    assign x2_last  = (mss_pkg::CNT_W'(x2_reg) + mss_pkg::CNT_W'(1)) == nr;
    assign x1_last  = (mss_pkg::CNT_W'(x1_reg) + mss_pkg::CNT_W'(1)) == nr;

    assign load_prev_row = (load_row_reg == '0) ? '0 : load_row_reg - mss_pkg::ROW_W'(1);
    assign x1_prev       = (x1_reg == '0) ? '0 : x1_reg - mss_pkg::ROW_W'(1);
    assign y1_prev       = (y1_reg == '0) ? '0 : y1_reg - mss_pkg::COL_W'(1);

    // Next state and counters
    always_comb
    begin
        state_next     = state_reg;
        load_row_next  = load_row_reg;
        load_col_next  = load_col_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        x2_next        = x2_reg;
        y2_next        = y2_reg;
        pend_op_next   = mss_pkg::OP_NONE;
        pend_top_next  = (x1_reg != '0);
        pend_left_next = (y1_reg != '0);

        unique case (state_reg)
            mss_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = mss_pkg::ST_LOAD;
                end
            end
            mss_pkg::ST_LOAD:
            begin
                if (!col_last)
                begin
                    load_col_next = load_col_reg + mss_pkg::COL_W'(1);
                    state_next    = mss_pkg::ST_IDLE;
                end
                else
                begin
                    load_col_next = '0;
                    if (!row_last)
                    begin
                        load_row_next = load_row_reg + mss_pkg::ROW_W'(1);
                        state_next    = mss_pkg::ST_IDLE;
                    end
                    else
                    begin
                        load_row_next = '0;
                        x1_next       = '0;
                        y1_next       = '0;
                        x2_next       = '0;
                        y2_next       = '0;
                        state_next    = mss_pkg::ST_CORNER;
                    end
                end
            end
            mss_pkg::ST_CORNER:
            begin
                pend_op_next = mss_pkg::OP_CORNER;
                y2_next      = y1_reg;
                state_next   = mss_pkg::ST_RECT;
            end
            mss_pkg::ST_RECT:
            begin
                pend_op_next = mss_pkg::OP_RECT;
                priority if (!y2_last)
                begin
                    y2_next = y2_reg + mss_pkg::COL_W'(1);
                end
                else if (!x2_last)
                begin
                    x2_next    = x2_reg + mss_pkg::ROW_W'(1);
                    state_next = mss_pkg::ST_CORNER;
                end
                else if (!y1_last)
                begin
                    y1_next    = y1_reg + mss_pkg::COL_W'(1);
                    x2_next    = x1_reg;
                    state_next = mss_pkg::ST_CORNER;
                end
                else if (!x1_last)
                begin
                    x1_next    = x1_reg + mss_pkg::ROW_W'(1);
                    x2_next    = x1_reg + mss_pkg::ROW_W'(1);
                    y1_next    = '0;
                    state_next = mss_pkg::ST_CORNER;
                end
                else
                begin
                    state_next = mss_pkg::ST_DRAIN;
                end
            end
            mss_pkg::ST_DRAIN:
            begin
                state_next = mss_pkg::ST_EMIT;
            end
            mss_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = mss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mss_pkg::ST_IDLE;
            end
        endcase

        if (restart)
        begin
            load_row_next = '0;
            load_col_next = '0;
        end
    end

    // Outputs
    always_comb
    begin
        ctrl            = '0;
        ctrl.op         = pend_op_reg;
        ctrl.m_top      = pend_top_reg;
        ctrl.m_left     = pend_left_reg;
        ctrl.waddr      = mss_pkg::mem_addr(load_row_reg, load_col_reg);
        ctrl.raddr0     = mss_pkg::mem_addr(load_prev_row, load_col_reg);
        ctrl.raddr1     = mss_pkg::mem_addr(x1_prev, y2_reg);
        ctrl.x1         = px1_reg;
        ctrl.y1         = py1_reg;
        ctrl.x2         = px2_reg;
        ctrl.y2         = py2_reg;

        unique case (state_reg)
            mss_pkg::ST_IDLE:
            begin
                ctrl.ready  = 1'b1;
                ctrl.op     = mss_pkg::OP_ROWSUM;
                ctrl.m_top  = (load_row_reg != '0);
                ctrl.m_left = (load_col_reg != '0);
            end
            mss_pkg::ST_LOAD:
            begin
                ctrl.op         = mss_pkg::OP_LOAD;
                ctrl.m_top      = (load_row_reg != '0);
                ctrl.m_left     = (load_col_reg != '0);
                ctrl.wr_en      = 1'b1;
                ctrl.scan_start = col_last && row_last;
            end
            mss_pkg::ST_CORNER:
            begin
                ctrl.raddr0 = mss_pkg::mem_addr(x2_reg, y1_prev);
                ctrl.raddr1 = mss_pkg::mem_addr(x1_prev, y1_prev);
            end
            mss_pkg::ST_RECT:
            begin
                ctrl.raddr0 = mss_pkg::mem_addr(x2_reg, y2_reg);
                ctrl.raddr1 = mss_pkg::mem_addr(x1_prev, y2_reg);
            end
            mss_pkg::ST_DRAIN:
            begin
                ctrl.wr_en = 1'b0;
            end
            mss_pkg::ST_EMIT:
            begin
                ctrl.res_load = out_free;
            end
            default:
            begin
                ctrl.wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mss_pkg::ST_IDLE;
            load_row_reg  <= '0;
            load_col_reg  <= '0;
            x1_reg        <= '0;
            y1_reg        <= '0;
            x2_reg        <= '0;
            y2_reg        <= '0;
            pend_op_reg   <= mss_pkg::OP_NONE;
            pend_top_reg  <= 1'b0;
            pend_left_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_row_reg  <= load_row_next;
            load_col_reg  <= load_col_next;
            x1_reg        <= x1_next;
            y1_reg        <= y1_next;
            x2_reg        <= x2_next;
            y2_reg        <= y2_next;
            pend_op_reg   <= pend_op_next;
            pend_top_reg  <= pend_top_next;
            pend_left_reg <= pend_left_next;
        end
    end

    // Tag of the rectangle whose table words return next cycle
    always_ff @(posedge clk)
    begin
        px1_reg <= x1_reg;
        py1_reg <= y1_reg;
        px2_reg <= x2_reg;
        py2_reg <= y2_reg;
    end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for the minimum-sum sub-rectangle search core.
module tb_top;

    import mss_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int ITEM_TARGET   = 580;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int HOLD_CYCLES   = 3000;
    localparam int LIMIT_CYCLES  = 2000000;

    // Indexes that decode to no register; a write there must change nothing
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = CFG_INDEX_W'(3);

    localparam logic signed [31:0] SAT_HI = 32'sd134217727;
    localparam logic signed [31:0] SAT_LO = -32'sd134217728;

    typedef struct {
        min_sum_t min_sum;
        start_t   row_start;
        count_t   row_count;
        start_t   col_start;
        count_t   col_count;
    } rect_result_t;

    // Flavours of cell content for one job
    typedef enum int {
        FILL_FULL,
        FILL_SMALL,
        FILL_EXTREME,
        FILL_POSITIVE
    } fill_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0]       cfg_wdata;

    mss_cell_if   cells_ch ();
    mss_result_if result_ch ();

    // Cells waiting to be offered, and search results still owed by the block
    energy_t      pending_cells[$];
    rect_result_t expected_rects[$];

    // Own copy of the block's state: sizes, fill position and summed-area table
    logic [CFG_W-1:0]   rows_cfg = CFG_SIZE_RST;
    logic [CFG_W-1:0]   cols_cfg = CFG_SIZE_RST;
    int                 fill_row = 0;
    int                 fill_col = 0;
    logic signed [31:0] area_sums[MAX_ROWS][MAX_COLS];

    int   cells_sent  = 0;
    int   mismatches  = 0;
    logic steady      = 1'b0;
    logic hold_off    = 1'b0;
    logic burst_armed = 1'b0;

    min_sum_subrectangle_search_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cells     (cells_ch.sink),
        .result    (result_ch.source)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Out-of-range sizes fold onto the nearest legal one
    function automatic int size_limit(input logic [CFG_W-1:0] v, input int maxv);
        if (v == '0)
        begin
            return 1;
        end
        if (int'(v) > maxv)
        begin
            return maxv;
        end
        return int'(v);
    endfunction

    // Exhaustive scan in top, left, bottom, right order; only a strictly
    // smaller sum displaces the current best, so ties keep the earliest
    function automatic rect_result_t search_min_rect(input int nr, input int nc);
        rect_result_t       res;
        logic signed [31:0] best;
        logic signed [31:0] s;
        int                 bx1;
        int                 by1;
        int                 bx2;
        int                 by2;
        best = 32'sh7FFFFFFF;
        bx1 = 0;
        by1 = 0;
        bx2 = 0;
        by2 = 0;
        for (int x1 = 0; x1 < nr; x1++)
            for (int y1 = 0; y1 < nc; y1++)
                for (int x2 = x1; x2 < nr; x2++)
                    for (int y2 = y1; y2 < nc; y2++)
                    begin
                        s = area_sums[x2][y2];
                        if (x1 > 0)
                            s -= area_sums[x1-1][y2];
                        if (y1 > 0)
                            s -= area_sums[x2][y1-1];
                        if (x1 > 0 && y1 > 0)
                            s += area_sums[x1-1][y1-1];
                        if (s < best)
                        begin
                            best = s;
                            bx1 = x1;
                            by1 = y1;
                            bx2 = x2;
                            by2 = y2;
                        end
                    end
        if (best > SAT_HI)
            best = SAT_HI;
        else if (best < SAT_LO)
            best = SAT_LO;
        res.min_sum   = min_sum_t'(best);
        res.row_start = start_t'(bx1);
        res.row_count = count_t'(bx2 - bx1 + 1);
        res.col_start = start_t'(by1);
        res.col_count = count_t'(by2 - by1 + 1);
        return res;
    endfunction

    // Fold one accepted cell into the table; the last cell of a job owes a result
    function automatic void absorb_cell(input energy_t e);
        int                 nr;
        int                 nc;
        logic signed [31:0] v;
        nr = size_limit(rows_cfg, MAX_ROWS);
        nc = size_limit(cols_cfg, MAX_COLS);
        if (fill_row >= nr || fill_col >= nc)
        begin
            fill_row = 0;
            fill_col = 0;
        end
        v = e;
        if (fill_row > 0)
            v += area_sums[fill_row-1][fill_col];
        if (fill_col > 0)
            v += area_sums[fill_row][fill_col-1];
        if (fill_row > 0 && fill_col > 0)
            v -= area_sums[fill_row-1][fill_col-1];
        area_sums[fill_row][fill_col] = v;
        if (fill_col + 1 < nc)
        begin
            fill_col++;
            return;
        end
        fill_col = 0;
        if (fill_row + 1 < nr)
        begin
            fill_row++;
            return;
        end
        fill_row = 0;
        expected_rects.insert(expected_rects.size(), search_min_rect(nr, nc));
    endfunction

    function automatic void check_field(input string field, input longint want,
                                        input longint got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    function automatic energy_t rand_energy(input fill_t fill);
        case (fill)
            FILL_FULL:
                return energy_t'($urandom_range(0, 65535));
            FILL_SMALL:
                return energy_t'(int'($urandom_range(0, 800)) - 400);
            FILL_EXTREME:
                case ($urandom_range(0, 4))
                    0: return energy_t'(16'sh8000);
                    1: return energy_t'(16'sh7FFF);
                    2: return energy_t'(0);
                    3: return energy_t'(-1);
                    default: return energy_t'(1);
                endcase
            default:
                return energy_t'($urandom_range(1, 100));
        endcase
    endfunction

    // Mostly small sizes, now and then zero or just above the usual range
    function automatic logic [CFG_W-1:0] pick_size();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return CFG_W'(8);
            default: return CFG_W'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic offer_cell(input energy_t e);
        pending_cells.insert(pending_cells.size(), e);
        cells_sent++;
    endtask

    task automatic queue_cells(input int count, input fill_t fill);
        for (int i = 0; i < count; i++)
            offer_cell(rand_energy(fill));
    endtask

    // Wait until every cell is taken and every result is back, then let the
    // table write of a trailing cell finish
    task automatic settle();
        while (pending_cells.size() != 0 || expected_rects.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Any write to a real register restarts loading at the first cell
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == CFG_ROWS_USED || idx == CFG_COLS_USED)
        begin
            if (idx == CFG_ROWS_USED)
                rows_cfg = val;
            else
                cols_cfg = val;
            fill_row = 0;
            fill_col = 0;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Cell driver: hold an offered item until it is taken, predict on
    // acceptance, then offer the next one unless this cycle idles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_ch.valid  <= 1'b0;
            cells_ch.energy <= '0;
        end
        else if (!cells_ch.valid || cells_ch.ready)
        begin
            if (cells_ch.valid)
            begin
                absorb_cell(pending_cells[0]);
                void'(pending_cells.pop_front());
            end
            if (pending_cells.size() != 0 && (steady || $urandom_range(0, 99) >= 16))
            begin
                cells_ch.valid  <= 1'b1;
                cells_ch.energy <= pending_cells[0];
            end
            else
            begin
                cells_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor: compare each accepted item with the oldest expectation,
    // and stall at random or for the long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin : result_check
                rect_result_t want;
                if (expected_rects.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got min_sum %0d",
                             $time, result_ch.min_sum);
                    mismatches++;
                end
                else
                begin
                    want = expected_rects.pop_front();
                    check_field("min_sum", want.min_sum, result_ch.min_sum);
                    check_field("row_start", want.row_start, result_ch.row_start);
                    check_field("row_count", want.row_count, result_ch.row_count);
                    check_field("col_start", want.col_start, result_ch.col_start);
                    check_field("col_count", want.col_count, result_ch.col_count);
                end
            end
            result_ch.ready <= !hold_off && (steady || $urandom_range(0, 99) >= 16);
        end
    end

    // Long receiver hold-off once the burst of same-sized jobs is queued, so
    // that one result sits in the output register and the next job stalls
    // the cell input behind it
    initial
    begin
        wait (burst_armed);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Mismatches found");
        $finish;
    end

    // Stimulus: directed jobs first, then random jobs, then drain and report
    initial
    begin
        int    job_no;
        int    nr;
        int    nc;
        fill_t fill;

        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        cells_ch.valid  = 1'b0;
        cells_ch.energy = '0;
        result_ch.ready = 1'b0;
        rst_n           = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-cell jobs: every cell is a job of its own, extremes of energy
        write_reg(CFG_ROWS_USED, CFG_W'(1));
        write_reg(CFG_COLS_USED, CFG_W'(1));
        offer_cell(energy_t'(16'sh8000));
        offer_cell(energy_t'(16'sh7FFF));
        offer_cell(energy_t'(0));
        offer_cell(energy_t'(-1));
        settle();

        // Zero sizes act as one
        write_reg(CFG_ROWS_USED, '0);
        write_reg(CFG_COLS_USED, '0);
        offer_cell(energy_t'(1));
        settle();

        // All-zero matrix: every rectangle ties, the first one must win;
        // then alternating extremes in the same shape
        write_reg(CFG_ROWS_USED, CFG_W'(2));
        write_reg(CFG_COLS_USED, CFG_W'(3));
        for (int i = 0; i < 6; i++)
            offer_cell(energy_t'(0));
        for (int i = 0; i < 6; i++)
            offer_cell((i % 2 == 0) ? energy_t'(16'sh7FFF) : energy_t'(16'sh8000));
        settle();

        // Register write part-way through a job: drop the loaded cells
        write_reg(CFG_ROWS_USED, CFG_W'(2));
        write_reg(CFG_COLS_USED, CFG_W'(2));
        queue_cells(3, FILL_FULL);
        settle();
        write_reg(CFG_COLS_USED, CFG_W'(2));
        queue_cells(4, FILL_SMALL);
        settle();

        // Burst of back-to-back 3x3 jobs for the hold-off
        write_reg(CFG_ROWS_USED, CFG_W'(3));
        write_reg(CFG_COLS_USED, CFG_W'(3));
        for (int i = 0; i < 6; i++)
            queue_cells(9, fill_t'($urandom_range(0, 3)));
        burst_armed = 1'b1;

        job_no = 0;
        while (cells_sent < ITEM_TARGET)
        begin
            job_no++;
            // Stretch with no idling on either side
            steady <= (job_no >= 20 && job_no < 32);
            if (job_no == 5 || job_no == 6 || job_no == 12 || job_no == 13
                || $urandom_range(0, 99) < 60)
            begin
                settle();
                if ($urandom_range(0, 14) == 0)
                    write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_A : CFG_SPARE_B,
                              CFG_W'($urandom_range(0, 127)));
                if (job_no == 5)
                begin
                    // Oversized row count folds to the maximum: one 64-row column
                    write_reg(CFG_ROWS_USED, CFG_W'(127));
                    write_reg(CFG_COLS_USED, CFG_W'(1));
                end
                else if (job_no == 12)
                begin
                    write_reg(CFG_ROWS_USED, CFG_W'(1));
                    write_reg(CFG_COLS_USED, CFG_W'(64));
                end
                else
                begin
                    write_reg(CFG_ROWS_USED, pick_size());
                    write_reg(CFG_COLS_USED, pick_size());
                end
            end
            nr = size_limit(rows_cfg, MAX_ROWS);
            nc = size_limit(cols_cfg, MAX_COLS);
            fill = fill_t'($urandom_range(0, 3));
            // Now and then abandon a job half-way with a restarting write
            if (nr * nc > 1 && $urandom_range(0, 9) == 0)
            begin
                queue_cells($urandom_range(1, nr * nc - 1), fill);
                settle();
                write_reg(CFG_ROWS_USED, rows_cfg);
            end
            queue_cells(nr * nc, fill);
        end

        steady <= 1'b0;
        while (pending_cells.size() != 0 || expected_rects.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- min_sum_subrectangle_search_core.f -----
rtl/mss_pkg.sv
rtl/mss_ifs.sv
rtl/mss_ram.sv
rtl/mss_alu.sv
rtl/mss_seq.sv
rtl/min_sum_subrectangle_search_core.sv
tb/tb_top.sv
